// ----- hw/rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, node record, codes and sequencer states.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MEM_SIZE   = 1024;
  localparam int LEVELS     = $clog2(MEM_SIZE);
  localparam int NODES      = 2 * MEM_SIZE - 1;
  localparam int ADDR_W     = $clog2(NODES);
  localparam int DEPTH_W    = $clog2(LEVELS + 1);
  localparam int POS_W      = LEVELS;
  localparam int SIZE_W     = LEVELS + 1;
  localparam int OWNER_BITS = 16;

  typedef enum logic [1:0] {
    KIND_UNUSED = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_SPLIT  = 2'd2,
    KIND_USED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    W_IDLE, W_RD, W_EV, W_BACK, W_SPL_L, W_SPL_R, W_MRG_RD, W_MRG_EV, W_FIN
  } wstate_t;

  typedef struct packed {
    kind_t                  kind;
    logic [OWNER_BITS-1:0]  owner;
    logic [SIZE_W-1:0]      request;
  } node_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    node_t             data;
  } node_wr_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [OWNER_BITS-1:0] owner;
    logic [SIZE_W-1:0]     size;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [POS_W-1:0]      block_start;
    logic [POS_W-1:0]      block_end;
    logic [SIZE_W-1:0]     recorded_size;
    logic [OWNER_BITS-1:0] owner;
  } res_t;

  // Ceiling log2 of a request size, for sizes of one and up.
  function automatic logic [DEPTH_W-1:0] ceil_log2(input logic [SIZE_W-1:0] size);
    logic [DEPTH_W-1:0] lg;
    lg = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if ((SIZE_W'(1) << i) < size) lg = DEPTH_W'(i + 1);
    end
    return lg;
  endfunction

  // Byte length of a node at a given tree depth.
  function automatic logic [SIZE_W-1:0] node_len(input logic [DEPTH_W-1:0] depth);
    return SIZE_W'(MEM_SIZE) >> depth;
  endfunction

endpackage

// ----- hw/rtl/bba_node_ram.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator node store
// One write and one registered read per cycle; the root reads as a free leaf
// until it is first written.
// ----------------------------------------------------------------------------
module bba_node_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  bba_pkg::node_wr_t         wr,
  input  logic [bba_pkg::ADDR_W-1:0] raddr,
  output bba_pkg::node_t            rdata
);

  bba_pkg::node_t mem [bba_pkg::NODES];
  bba_pkg::node_t rd_q;
  logic           root_written;
  logic           root_default;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
  end

  // Track whether the root has been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_written <= 1'b0;
      root_default <= 1'b1;
    end else begin
      if (wr.en && wr.addr == '0) root_written <= 1'b1;
      root_default <= (raddr == '0) && !root_written;
    end
  end

  always_comb begin
    if (root_default) begin
      rdata = '{kind: bba_pkg::KIND_FREE, owner: '0, request: '0};
    end else begin
      rdata = rd_q;
    end
  end

endmodule

// ----- hw/rtl/bba_walker.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator tree walker
// Sequencer that walks the node tree in preorder, one node per visit, for
// allocation with splitting and for release with upward merging.
// ----------------------------------------------------------------------------
module bba_walker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  bba_pkg::req_t              req,
  output logic                       done,
  output bba_pkg::res_t              res,
  output bba_pkg::node_wr_t          wr,
  output logic [bba_pkg::ADDR_W-1:0] raddr,
  input  bba_pkg::node_t             rdata
);

  bba_pkg::wstate_t                 state, state_next;
  bba_pkg::cmd_t                    op;
  logic [bba_pkg::ADDR_W-1:0]       idx;
  logic [bba_pkg::DEPTH_W-1:0]      depth;
  logic [bba_pkg::POS_W-1:0]        pos;
  logic [bba_pkg::DEPTH_W-1:0]      want_depth;
  logic [bba_pkg::OWNER_BITS-1:0]   owner;
  logic [bba_pkg::SIZE_W-1:0]       size;
  bba_pkg::res_t                    res_q;

  logic [bba_pkg::SIZE_W-1:0]       len;
  logic [bba_pkg::POS_W-1:0]        len_pos;
  logic [bba_pkg::ADDR_W-1:0]       left_idx;
  logic [bba_pkg::ADDR_W-1:0]       right_idx;
  logic [bba_pkg::ADDR_W-1:0]       parent_idx;
  logic [bba_pkg::ADDR_W-1:0]       sib_idx;
  logic                             bad_size;
  logic                             hit_used;

  assign len        = bba_pkg::node_len(depth);
  assign len_pos    = len[bba_pkg::POS_W-1:0];
  assign left_idx   = {idx[bba_pkg::ADDR_W-2:0], 1'b1};
  assign right_idx  = left_idx + bba_pkg::ADDR_W'(1);
  assign parent_idx = (idx - bba_pkg::ADDR_W'(1)) >> 1;
  assign sib_idx    = idx[0] ? idx + bba_pkg::ADDR_W'(1) : idx - bba_pkg::ADDR_W'(1);
  assign bad_size   = (req.size == '0) || (req.size > bba_pkg::SIZE_W'(bba_pkg::MEM_SIZE));
  assign hit_used   = (rdata.kind == bba_pkg::KIND_USED) && (rdata.owner == owner);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::W_IDLE: begin
        if (start) state_next = bad_size && req.cmd == bba_pkg::CMD_ALLOC ?
                                bba_pkg::W_FIN : bba_pkg::W_RD;
      end
      bba_pkg::W_RD: state_next = bba_pkg::W_EV;
      bba_pkg::W_EV: begin
        if (op == bba_pkg::CMD_ALLOC) begin
          if (rdata.kind == bba_pkg::KIND_FREE) begin
            if (depth == want_depth)     state_next = bba_pkg::W_FIN;
            else if (depth > want_depth) state_next = bba_pkg::W_BACK;
            else                         state_next = bba_pkg::W_SPL_L;
          end else if (rdata.kind == bba_pkg::KIND_SPLIT) begin
            state_next = bba_pkg::W_RD;
          end else begin
            state_next = bba_pkg::W_BACK;
          end
        end else begin
          if (hit_used) begin
            state_next = (idx == '0) ? bba_pkg::W_FIN : bba_pkg::W_MRG_RD;
          end else if (rdata.kind == bba_pkg::KIND_SPLIT) begin
            state_next = bba_pkg::W_RD;
          end else begin
            state_next = bba_pkg::W_BACK;
          end
        end
      end
      bba_pkg::W_BACK: begin
        if (idx == '0)  state_next = bba_pkg::W_FIN;
        else if (idx[0]) state_next = bba_pkg::W_RD;
      end
      bba_pkg::W_SPL_L:  state_next = bba_pkg::W_SPL_R;
      bba_pkg::W_SPL_R:  state_next = bba_pkg::W_RD;
      bba_pkg::W_MRG_RD: state_next = bba_pkg::W_MRG_EV;
      bba_pkg::W_MRG_EV: begin
        if (rdata.kind == bba_pkg::KIND_FREE && parent_idx != '0) begin
          state_next = bba_pkg::W_MRG_RD;
        end else begin
          state_next = bba_pkg::W_FIN;
        end
      end
      bba_pkg::W_FIN: state_next = bba_pkg::W_IDLE;
      default:        state_next = bba_pkg::W_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    wr    = '0;
    raddr = (state == bba_pkg::W_MRG_RD) ? sib_idx : idx;
    done  = (state == bba_pkg::W_FIN);
    case (state)
      bba_pkg::W_EV: begin
        if (op == bba_pkg::CMD_ALLOC && rdata.kind == bba_pkg::KIND_FREE) begin
          if (depth == want_depth) begin
            wr = '{en: 1'b1, addr: idx,
                   data: '{kind: bba_pkg::KIND_USED, owner: owner, request: size}};
          end else if (depth < want_depth) begin
            wr = '{en: 1'b1, addr: idx,
                   data: '{kind: bba_pkg::KIND_SPLIT, owner: rdata.owner,
                           request: rdata.request}};
          end
        end else if (op == bba_pkg::CMD_FREE && hit_used) begin
          wr = '{en: 1'b1, addr: idx,
                 data: '{kind: bba_pkg::KIND_FREE, owner: '0, request: '0}};
        end
      end
      bba_pkg::W_SPL_L: begin
        wr = '{en: 1'b1, addr: left_idx,
               data: '{kind: bba_pkg::KIND_FREE, owner: '0, request: '0}};
      end
      bba_pkg::W_SPL_R: begin
        wr = '{en: 1'b1, addr: right_idx,
               data: '{kind: bba_pkg::KIND_FREE, owner: '0, request: '0}};
      end
      bba_pkg::W_MRG_EV: begin
        if (rdata.kind == bba_pkg::KIND_FREE) begin
          wr = '{en: 1'b1, addr: parent_idx,
                 data: '{kind: bba_pkg::KIND_FREE, owner: '0, request: '0}};
        end
      end
      default: wr = '0;
    endcase
  end

  assign res = res_q;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= bba_pkg::W_IDLE;
    else     state <= state_next;
  end

  // Walk position and result registers.
  always_ff @(posedge clk) begin
    case (state)
      bba_pkg::W_IDLE: begin
        if (start) begin
          op         <= req.cmd;
          owner      <= req.owner;
          size       <= req.size;
          want_depth <= bba_pkg::DEPTH_W'(bba_pkg::LEVELS) - bba_pkg::ceil_log2(req.size);
          idx        <= '0;
          depth      <= '0;
          pos        <= '0;
          res_q      <= '{status: bba_pkg::ST_BAD_SIZE, block_start: '0, block_end: '0,
                          recorded_size: '0, owner: req.owner};
        end
      end
      bba_pkg::W_EV: begin
        if (op == bba_pkg::CMD_ALLOC) begin
          if (rdata.kind == bba_pkg::KIND_FREE && depth == want_depth) begin
            res_q.status        <= bba_pkg::ST_OK;
            res_q.block_start   <= pos;
            res_q.block_end     <= bba_pkg::POS_W'(bba_pkg::SIZE_W'(pos) + len
                                                   - bba_pkg::SIZE_W'(1));
            res_q.recorded_size <= size;
          end else if (rdata.kind == bba_pkg::KIND_SPLIT) begin
            idx   <= left_idx;
            depth <= depth + bba_pkg::DEPTH_W'(1);
          end
        end else begin
          if (hit_used) begin
            res_q.status        <= bba_pkg::ST_OK;
            res_q.block_start   <= pos;
            res_q.block_end     <= bba_pkg::POS_W'(bba_pkg::SIZE_W'(pos) + len
                                                   - bba_pkg::SIZE_W'(1));
            res_q.recorded_size <= rdata.request;
          end else if (rdata.kind == bba_pkg::KIND_SPLIT) begin
            idx   <= left_idx;
            depth <= depth + bba_pkg::DEPTH_W'(1);
          end
        end
      end
      bba_pkg::W_BACK: begin
        if (idx == '0) begin
          res_q.status <= (op == bba_pkg::CMD_ALLOC) ? bba_pkg::ST_NO_FIT
                                                     : bba_pkg::ST_NO_OWNER;
        end else if (idx[0]) begin
          idx <= idx + bba_pkg::ADDR_W'(1);
          pos <= pos + len_pos;
        end else begin
          idx   <= parent_idx;
          depth <= depth - bba_pkg::DEPTH_W'(1);
          pos   <= pos - len_pos;
        end
      end
      bba_pkg::W_SPL_R: begin
        idx   <= left_idx;
        depth <= depth + bba_pkg::DEPTH_W'(1);
      end
      bba_pkg::W_MRG_EV: begin
        if (rdata.kind == bba_pkg::KIND_FREE) idx <= parent_idx;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/buddy_allocator_by_owner.sv -----
// Flow: a rejected size passes from request transfer to the finish state directly;
// any other request walks the tree in preorder, visiting nodes one at a time, and a
// release then merges upward level by level through the node store.
// Throughput: one request at a time; s_tready is low from acceptance until
// the result transfer completes.
// Reset: synchronous; the tree becomes one free root at once, no clearing pass.
// ----------------------------------------------------------------------------
// Buddy allocator by owner
// Stream front end holding one request and one result around the tree walker.
// ----------------------------------------------------------------------------
module buddy_allocator_by_owner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // owner_id[15:0], request_size[26:16], zero pad
  input  logic [0:0]  s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // status[1:0], block_start[11:2], block_end[21:12],
                                 // recorded_size[32:22], result_owner[48:33], zero pad
);

  logic              busy;
  logic              start;
  bba_pkg::req_t     req;
  logic              done;
  bba_pkg::res_t     res;
  bba_pkg::res_t     out_q;
  bba_pkg::node_wr_t wr;
  logic [bba_pkg::ADDR_W-1:0] raddr;
  bba_pkg::node_t    rdata;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign req      = '{cmd: bba_pkg::cmd_t'(s_tuser[0]), owner: s_tdata[15:0],
                      size: s_tdata[26:16]};

  // Busy from request transfer until result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (start) busy <= 1'b1;
      else if (m_tvalid && m_tready) busy <= 1'b0;
      if (done) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Result holding register.
  always_ff @(posedge clk) begin
    if (done) out_q <= res;
  end

  assign m_tdata = {7'd0, out_q.owner, out_q.recorded_size, out_q.block_end,
                    out_q.block_start, out_q.status};

  bba_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .done  (done),
    .res   (res),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  bba_node_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
